/* hw/rtl/ivr_pkg.sv */
// shared types and constants for the 2d impulse velocity resolve pipeline
// no dependencies; used by every module of the block

package ivr_pkg;

  localparam int unsigned ONE_Q16  = 65536;
  localparam int unsigned QUOT_W   = 54;   // quotient bits of the share division
  localparam int unsigned NUM_W    = 85;   // dividend bits: inv mass times p
  localparam int unsigned FRONT_LAT = 6;
  localparam int unsigned BACK_LAT  = 2;
  localparam int unsigned TOTAL_LAT = FRONT_LAT + QUOT_W + BACK_LAT;

  typedef enum logic [1:0] {
    OUT_IMPULSE  = 2'd0,
    OUT_SEPARATE = 2'd1,
    OUT_STATIC   = 2'd2
  } outcome_e;

  // data that rides along the pipe untouched by the arithmetic
  typedef struct packed {
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    outcome_e           outcome;
  } side_t;

endpackage

/* hw/rtl/impulse_velocity_resolve_2d_unit.sv */
// top level of the 2d impulse velocity resolve pipeline
// depends on ivr_pkg, ivr_front, ivr_div, ivr_back
//
// usage:
//   one contact item enters when start_i is high and busy_o is low; busy_o
//   stays low, so a new item can enter in every clock cycle.
//   each item gives exactly one result: valid_o is high for one cycle with
//   new_vel_*_o and outcome_o; the result must be taken in that cycle.
// throughput: one item per cycle. the front end forms the relative normal
//   velocity, the impulse numerator and the share dividends, then the
//   bit-per-stage share divider follows (one stage per quotient bit),
//   and the back end applies the deltas and saturates.
// outcome_o: 0 impulse applied, 1 separating, 2 both bodies static; in the
//   last two cases the velocities come back unchanged.
// reset: rst_ni low clears every valid bit at once; items in flight are
//   dropped and no result appears until new items arrive.
// there is no back pressure from the receiver.

module impulse_velocity_resolve_2d_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] vel_a_x_i,
  input  logic signed [31:0] vel_a_y_i,
  input  logic signed [31:0] vel_b_x_i,
  input  logic signed [31:0] vel_b_y_i,
  input  logic signed [17:0] normal_x_i,
  input  logic signed [17:0] normal_y_i,
  input  logic [30:0]        inv_mass_a_i,
  input  logic [30:0]        inv_mass_b_i,
  input  logic [16:0]        bounce_a_i,
  input  logic [16:0]        bounce_b_i,
  output logic               valid_o,
  output logic signed [31:0] new_vel_a_x_o,
  output logic signed [31:0] new_vel_a_y_o,
  output logic signed [31:0] new_vel_b_x_o,
  output logic signed [31:0] new_vel_b_y_o,
  output logic [1:0]         outcome_o
);

  ivr_pkg::side_t in_side, f_side, d_side;
  logic           f_valid, d_valid;
  logic [84:0]    f_num_a, f_num_b;
  logic [31:0]    f_den;
  logic [53:0]    d_quot_a, d_quot_b;
  logic           accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    in_side.vax     = vel_a_x_i;
    in_side.vay     = vel_a_y_i;
    in_side.vbx     = vel_b_x_i;
    in_side.vby     = vel_b_y_i;
    in_side.nx      = normal_x_i;
    in_side.ny      = normal_y_i;
    in_side.outcome = ivr_pkg::OUT_IMPULSE;  // decided in the front end
  end

  ivr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .side_i     (in_side),
    .inv_a_i    (inv_mass_a_i),
    .inv_b_i    (inv_mass_b_i),
    .bounce_a_i (bounce_a_i),
    .bounce_b_i (bounce_b_i),
    .valid_o    (f_valid),
    .side_o     (f_side),
    .num_a_o    (f_num_a),
    .num_b_o    (f_num_b),
    .den_o      (f_den)
  );

  ivr_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (f_valid),
    .side_i   (f_side),
    .num_a_i  (f_num_a),
    .num_b_i  (f_num_b),
    .den_i    (f_den),
    .valid_o  (d_valid),
    .side_o   (d_side),
    .quot_a_o (d_quot_a),
    .quot_b_o (d_quot_b)
  );

  ivr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (d_valid),
    .side_i        (d_side),
    .quot_a_i      (d_quot_a),
    .quot_b_i      (d_quot_b),
    .valid_o       (valid_o),
    .new_vel_a_x_o (new_vel_a_x_o),
    .new_vel_a_y_o (new_vel_a_y_o),
    .new_vel_b_x_o (new_vel_b_x_o),
    .new_vel_b_y_o (new_vel_b_y_o),
    .outcome_o     (outcome_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(accept, ivr_pkg::TOTAL_LAT) |-> valid_o)
    else $error("result missing at expected latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, ivr_pkg::TOTAL_LAT))
    else $error("result without a matching item");

  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (outcome_o == ivr_pkg::OUT_IMPULSE || outcome_o == ivr_pkg::OUT_SEPARATE ||
                 outcome_o == ivr_pkg::OUT_STATIC))
    else $error("illegal outcome code");

  a_reset_clear: assert property (@(posedge clk_i) !rst_ni |=> !valid_o)
    else $error("result right after reset");

endmodule

/* hw/rtl/ivr_front.sv */
// front end: relative normal velocity, impulse numerator and share dividends
// depends on ivr_pkg

module ivr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  ivr_pkg::side_t      side_i,
  input  logic [30:0]         inv_a_i,
  input  logic [30:0]         inv_b_i,
  input  logic [16:0]         bounce_a_i,
  input  logic [16:0]         bounce_b_i,
  output logic                valid_o,
  output ivr_pkg::side_t      side_o,
  output logic [84:0]         num_a_o,
  output logic [84:0]         num_b_o,
  output logic [31:0]         den_o
);

  logic [5:0] v_q;

  // stage 1
  ivr_pkg::side_t     s1_side_q;
  logic signed [32:0] s1_rvx_q, s1_rvy_q;
  logic [30:0]        s1_inva_q, s1_invb_q;
  logic [16:0]        s1_e_q;
  // stage 2
  ivr_pkg::side_t     s2_side_q;
  logic signed [50:0] s2_mx_q, s2_my_q;
  logic [30:0]        s2_inva_q, s2_invb_q;
  logic [31:0]        s2_den_q;
  logic [16:0]        s2_e_q;
  // stage 3
  ivr_pkg::side_t     s3_side_q;
  logic [35:0]        s3_mag_q;
  logic [17:0]        s3_onee_q;
  logic [30:0]        s3_inva_q, s3_invb_q;
  logic [31:0]        s3_den_q;
  // stage 4
  ivr_pkg::side_t     s4_side_q;
  logic [53:0]        s4_p_q;
  logic [30:0]        s4_inva_q, s4_invb_q;
  logic [31:0]        s4_den_q;
  // stage 5
  ivr_pkg::side_t     s5_side_q;
  logic [57:0]        s5_alo_q, s5_ahi_q, s5_blo_q, s5_bhi_q;
  logic [31:0]        s5_den_q;
  // stage 6
  ivr_pkg::side_t     s6_side_q;
  logic [84:0]        s6_na_q, s6_nb_q;
  logic [31:0]        s6_den_q;

  logic signed [51:0] vn;
  logic signed [35:0] vn16;
  logic signed [36:0] vn_neg;
  ivr_pkg::outcome_e  outcome_d;
  ivr_pkg::side_t     s3_side_d;

  always_comb begin
    vn     = {s2_mx_q[50], s2_mx_q} + {s2_my_q[50], s2_my_q};
    vn16   = vn[51:16];
    vn_neg = -{vn16[35], vn16};
    if (vn > 52'sd0) begin
      outcome_d = ivr_pkg::OUT_SEPARATE;
    end else if (s2_den_q == 32'd0) begin
      outcome_d = ivr_pkg::OUT_STATIC;
    end else begin
      outcome_d = ivr_pkg::OUT_IMPULSE;
    end
    s3_side_d         = s2_side_q;
    s3_side_d.outcome = outcome_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_side_q <= side_i;
    s1_rvx_q  <= {side_i.vbx[31], side_i.vbx} - {side_i.vax[31], side_i.vax};
    s1_rvy_q  <= {side_i.vby[31], side_i.vby} - {side_i.vay[31], side_i.vay};
    s1_inva_q <= inv_a_i;
    s1_invb_q <= inv_b_i;
    s1_e_q    <= (bounce_a_i < bounce_b_i) ? bounce_a_i : bounce_b_i;

    s2_side_q <= s1_side_q;
    s2_mx_q   <= s1_rvx_q * s1_side_q.nx;
    s2_my_q   <= s1_rvy_q * s1_side_q.ny;
    s2_inva_q <= s1_inva_q;
    s2_invb_q <= s1_invb_q;
    s2_den_q  <= {1'b0, s1_inva_q} + {1'b0, s1_invb_q};
    s2_e_q    <= s1_e_q;

    s3_side_q         <= s3_side_d;
    s3_mag_q          <= vn_neg[35:0];
    s3_onee_q         <= 18'(ivr_pkg::ONE_Q16) + {1'b0, s2_e_q};
    s3_inva_q         <= s2_inva_q;
    s3_invb_q         <= s2_invb_q;
    s3_den_q          <= s2_den_q;

    s4_side_q <= s3_side_q;
    s4_p_q    <= 54'(s3_onee_q) * 54'(s3_mag_q);
    s4_inva_q <= s3_inva_q;
    s4_invb_q <= s3_invb_q;
    s4_den_q  <= s3_den_q;

    // split p into two 27-bit halves to keep each multiplier narrow
    s5_side_q <= s4_side_q;
    s5_alo_q  <= 58'(s4_inva_q) * 58'(s4_p_q[26:0]);
    s5_ahi_q  <= 58'(s4_inva_q) * 58'(s4_p_q[53:27]);
    s5_blo_q  <= 58'(s4_invb_q) * 58'(s4_p_q[26:0]);
    s5_bhi_q  <= 58'(s4_invb_q) * 58'(s4_p_q[53:27]);
    s5_den_q  <= s4_den_q;

    s6_side_q <= s5_side_q;
    s6_na_q   <= 85'(s5_alo_q) + (85'(s5_ahi_q) << 27);
    s6_nb_q   <= 85'(s5_blo_q) + (85'(s5_bhi_q) << 27);
    s6_den_q  <= s5_den_q;
  end

  assign valid_o = v_q[5];
  assign side_o  = s6_side_q;
  assign num_a_o = s6_na_q;
  assign num_b_o = s6_nb_q;
  assign den_o   = s6_den_q;

endmodule

/* hw/rtl/ivr_div.sv */
// pipelined restoring divider, one quotient bit per stage, two lanes on one divisor
// depends on ivr_pkg

module ivr_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  ivr_pkg::side_t      side_i,
  input  logic [84:0]         num_a_i,
  input  logic [84:0]         num_b_i,
  input  logic [31:0]         den_i,
  output logic                valid_o,
  output ivr_pkg::side_t      side_o,
  output logic [53:0]         quot_a_o,
  output logic [53:0]         quot_b_o
);

  localparam int unsigned QW = ivr_pkg::QUOT_W;

  logic           v_q    [QW];
  ivr_pkg::side_t side_q [QW];
  logic [31:0]    den_q  [QW];
  logic [31:0]    ra_q   [QW];
  logic [31:0]    rb_q   [QW];
  logic [53:0]    la_q   [QW];
  logic [53:0]    lb_q   [QW];
  logic [53:0]    qa_q   [QW];
  logic [53:0]    qb_q   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic           v_in;
    ivr_pkg::side_t side_in;
    logic [31:0]    den_in, ra_in, rb_in;
    logic [53:0]    la_in, lb_in, qa_in, qb_in;
    logic [32:0]    ta, tb;
    logic           ge_a, ge_b;

    if (k == 0) begin : g_first
      // quotient fits 54 bits, so the top dividend bits are already below den
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign den_in  = den_i;
      assign ra_in   = {1'b0, num_a_i[84:54]};
      assign rb_in   = {1'b0, num_b_i[84:54]};
      assign la_in   = num_a_i[53:0];
      assign lb_in   = num_b_i[53:0];
      assign qa_in   = '0;
      assign qb_in   = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
      assign den_in  = den_q[k-1];
      assign ra_in   = ra_q[k-1];
      assign rb_in   = rb_q[k-1];
      assign la_in   = la_q[k-1];
      assign lb_in   = lb_q[k-1];
      assign qa_in   = qa_q[k-1];
      assign qb_in   = qb_q[k-1];
    end

    assign ta   = {ra_in, la_in[53]};
    assign tb   = {rb_in, lb_in[53]};
    assign ge_a = ta >= {1'b0, den_in};
    assign ge_b = tb >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_in;
      den_q[k]  <= den_in;
      ra_q[k]   <= ge_a ? 32'(ta - {1'b0, den_in}) : ta[31:0];
      rb_q[k]   <= ge_b ? 32'(tb - {1'b0, den_in}) : tb[31:0];
      la_q[k]   <= {la_in[52:0], 1'b0};
      lb_q[k]   <= {lb_in[52:0], 1'b0};
      qa_q[k]   <= {qa_in[52:0], ge_a};
      qb_q[k]   <= {qb_in[52:0], ge_b};
    end
  end

  assign valid_o  = v_q[QW-1];
  assign side_o   = side_q[QW-1];
  assign quot_a_o = qa_q[QW-1];
  assign quot_b_o = qb_q[QW-1];

  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(valid_i, QW) |-> valid_o)
    else $error("divider lost an item");

endmodule

/* hw/rtl/ivr_back.sv */
// back end: velocity deltas along the normal, saturation and outcome select
// depends on ivr_pkg

module ivr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  ivr_pkg::side_t      side_i,
  input  logic [53:0]         quot_a_i,
  input  logic [53:0]         quot_b_i,
  output logic                valid_o,
  output logic signed [31:0]  new_vel_a_x_o,
  output logic signed [31:0]  new_vel_a_y_o,
  output logic signed [31:0]  new_vel_b_x_o,
  output logic signed [31:0]  new_vel_b_y_o,
  output logic [1:0]          outcome_o
);

  function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
    logic signed [31:0] r;
    if (x > 42'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -42'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  logic               b1_v_q, b2_v_q;
  ivr_pkg::side_t     b1_side_q;
  logic signed [56:0] b1_pax_q, b1_pay_q, b1_pbx_q, b1_pby_q;
  logic signed [38:0] ga, gb;

  logic signed [31:0] nax_q, nay_q, nbx_q, nby_q;
  logic [1:0]         outcome_q;

  logic signed [41:0] nax, nay, nbx, nby;

  assign ga = {1'b0, quot_a_i[53:16]};
  assign gb = {1'b0, quot_b_i[53:16]};

  always_comb begin
    // arithmetic shift of the product gives the floor
    nax = {{10{b1_side_q.vax[31]}}, b1_side_q.vax} - {b1_pax_q[56], b1_pax_q[56:16]};
    nay = {{10{b1_side_q.vay[31]}}, b1_side_q.vay} - {b1_pay_q[56], b1_pay_q[56:16]};
    nbx = {{10{b1_side_q.vbx[31]}}, b1_side_q.vbx} + {b1_pbx_q[56], b1_pbx_q[56:16]};
    nby = {{10{b1_side_q.vby[31]}}, b1_side_q.vby} + {b1_pby_q[56], b1_pby_q[56:16]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
    end else begin
      b1_v_q <= valid_i;
      b2_v_q <= b1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_side_q <= side_i;
    b1_pax_q  <= ga * side_i.nx;
    b1_pay_q  <= ga * side_i.ny;
    b1_pbx_q  <= gb * side_i.nx;
    b1_pby_q  <= gb * side_i.ny;

    outcome_q <= b1_side_q.outcome;
    if (b1_side_q.outcome == ivr_pkg::OUT_IMPULSE) begin
      nax_q <= sat32(nax);
      nay_q <= sat32(nay);
      nbx_q <= sat32(nbx);
      nby_q <= sat32(nby);
    end else begin
      nax_q <= b1_side_q.vax;
      nay_q <= b1_side_q.vay;
      nbx_q <= b1_side_q.vbx;
      nby_q <= b1_side_q.vby;
    end
  end

  assign valid_o       = b2_v_q;
  assign new_vel_a_x_o = nax_q;
  assign new_vel_a_y_o = nay_q;
  assign new_vel_b_x_o = nbx_q;
  assign new_vel_b_y_o = nby_q;
  assign outcome_o     = outcome_q;

endmodule
